>>> design/quaternion_to_euler_angles_top_assert.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// signal must lie in [lo, hi] whenever cond holds
`define QTE_ASSERT_RANGE(lbl, cond, sig, lo, hi) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (((sig) >= (lo)) && ((sig) <= (hi)))) \
        else $error("range check failed");

// signal must hold its value on the cycle after cond
`define QTE_ASSERT_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> $stable(sig)) \
        else $error("hold check failed");

`endif

>>> design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants and the CORDIC angle table for the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES = 16;    // 8 .. 32
    localparam int SQ_STEPS      = 29;    // root digits of a 58-bit radicand
    localparam int SUM_W         = 34;    // Q6.28 product sums
    localparam int S_W           = 30;    // clamped sine term
    localparam int CW            = 38;    // CORDIC x/y datapath
    localparam int ZW            = 26;    // angle, 2^-16 degree
    localparam int ROOT_W        = 29;
    localparam int REM_W         = 31;
    localparam int RAD_W         = 58;

    localparam logic signed [SUM_W-1:0] ONE_Q28  = SUM_W'(64'sd268435456);
    localparam logic signed [ZW-1:0]    DEG90    = ZW'(64'sd5898240);
    localparam logic signed [16:0]      ROLL_LIM  = 17'sd11520;
    localparam logic signed [16:0]      PITCH_LIM = 17'sd5760;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [S_W-1:0]   s;
    } t_car;

    // atan(2^-i) in 2^-16 degree, rounded
    function automatic logic signed [ZW-1:0] f_atan(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: quadrant fold, then one micro-rotation per
// register stage, all advancing only while i_en is high.
// ----------------------------------------------------------------------------
module qte_cordic
    import qte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_zero
);

    logic signed [CW-1:0] r_x [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_y [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z [0:CORDIC_STAGES];
    logic                 r_zero [0:CORDIC_STAGES];

    // fold left half-plane by +-90 degrees
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= DEG90;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -DEG90;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = f_atan(k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                if (r_y[k] >= 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ANG;
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ANG;
                end
            end
        end
    end

    assign o_z    = r_z[CORDIC_STAGES];
    assign o_zero = r_zero[CORDIC_STAGES];

endmodule

>>> design/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Attitude quaternion (Q2.14) to ZYX Euler angles in 1/64 degree.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_quat_w/x/y/z
//  out     | output    | o_out_valid / i_out_ready  | o_roll_deg/pitch_deg/yaw_deg
//
// One transaction per cycle while the output does not stall; registers in
// order: products, sums, square, radicand, 29 square-root digit stages,
// CORDIC fold plus micro-rotations, rounding.
// The whole pipeline advances together; it holds when the output stalls.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_top_assert.svh"

module quaternion_to_euler_angles_top
    import qte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_roll_deg,
    output logic signed [13:0] o_pitch_deg,
    output logic signed [14:0] o_yaw_deg
);

    localparam int LAT = CORDIC_STAGES + SQ_STEPS + 6;

    logic w_adv;
    logic r_vld [0:LAT-1];

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // stage 1: products
    logic signed [31:0] r_wx, r_yz, r_wz, r_xy, r_wy, r_zx, r_xx, r_yy, r_zz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
    end

    // stage 2: product sums, sine term clamped to +-1
    logic signed [SUM_W-1:0] w_s;
    t_car                    r_car2, r_car3;
    assign w_s = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_car2.sr <= (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
            r_car2.cr <= ONE_Q28 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
            r_car2.sy <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
            r_car2.cy <= ONE_Q28 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
            if (w_s > ONE_Q28)       r_car2.s <= S_W'(ONE_Q28);
            else if (w_s < -ONE_Q28) r_car2.s <= S_W'(-ONE_Q28);
            else                     r_car2.s <= S_W'(w_s);
        end
    end

    // stage 3: s squared
    logic signed [2*S_W-1:0] w_s2;
    logic        [56:0]      r_s2;
    assign w_s2 = r_car2.s * r_car2.s;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2   <= w_s2[56:0];
            r_car3 <= r_car2;
        end
    end

    // stage 4 and on: radicand, then one root digit per stage
    logic [RAD_W-1:0]  r_nsh  [0:SQ_STEPS];
    logic [REM_W-1:0]  r_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] r_root [0:SQ_STEPS];
    t_car              r_car  [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nsh[0]  <= (RAD_W'(1) << 56) - RAD_W'(r_s2);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_car[0]  <= r_car3;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [REM_W+1:0] w_rt;
        logic [REM_W+1:0] w_tr;
        assign w_rt = {r_rem[k], r_nsh[k][RAD_W-1 -: 2]};
        assign w_tr = {2'b00, r_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_nsh[k+1] <= r_nsh[k] << 2;
                r_car[k+1] <= r_car[k];
                if (w_rt >= w_tr) begin
                    r_rem[k+1]  <= REM_W'(w_rt - w_tr);
                    r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= REM_W'(w_rt);
                    r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // CORDIC lanes
    logic signed [ZW-1:0] w_z_roll, w_z_pitch, w_z_yaw;
    logic                 w_zero_roll, w_zero_pitch, w_zero_yaw;

    qte_cordic u_roll (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (CW'(r_car[SQ_STEPS].cr)),
        .i_y    (CW'(r_car[SQ_STEPS].sr)),
        .o_z    (w_z_roll),
        .o_zero (w_zero_roll)
    );

    qte_cordic u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    ($signed({{(CW-ROOT_W){1'b0}}, r_root[SQ_STEPS]})),
        .i_y    (CW'(r_car[SQ_STEPS].s)),
        .o_z    (w_z_pitch),
        .o_zero (w_zero_pitch)
    );

    qte_cordic u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (CW'(r_car[SQ_STEPS].cy)),
        .i_y    (CW'(r_car[SQ_STEPS].sy)),
        .o_z    (w_z_yaw),
        .o_zero (w_zero_yaw)
    );

    // rounding to 1/64 degree and saturation
    function automatic logic signed [16:0] f_round(input logic signed [ZW-1:0] z,
                                                  input logic zero,
                                                  input logic signed [16:0] lim);
        logic signed [ZW:0] t;
        logic signed [16:0] r;
        t = (ZW+1)'(z) + (ZW+1)'(512);
        r = 17'(t >>> 10);
        if (zero)         r = '0;
        else if (r > lim)  r = lim;
        else if (r < -lim) r = -lim;
        return r;
    endfunction

    logic signed [16:0] w_roll, w_pitch, w_yaw;
    assign w_roll  = f_round(w_z_roll, w_zero_roll, ROLL_LIM);
    assign w_pitch = f_round(w_z_pitch, w_zero_pitch, PITCH_LIM);
    assign w_yaw   = f_round(w_z_yaw, w_zero_yaw, ROLL_LIM);

    logic signed [14:0] r_roll, r_yaw;
    logic signed [13:0] r_pitch;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll  <= w_roll[14:0];
            r_pitch <= w_pitch[13:0];
            r_yaw   <= w_yaw[14:0];
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_roll_deg  = r_roll;
    assign o_pitch_deg = r_pitch;
    assign o_yaw_deg   = r_yaw;

    // assertions
    `QTE_ASSERT_RANGE(a_pitch_lim, o_out_valid, o_pitch_deg, -14'sd5760, 14'sd5760)
    `QTE_ASSERT_RANGE(a_roll_lim, o_out_valid, o_roll_deg, -15'sd11520, 15'sd11520)
    `QTE_ASSERT_RANGE(a_root_lim, r_vld[SQ_STEPS+3], r_root[SQ_STEPS], 29'd0, 29'd268435456)
    `QTE_ASSERT_HOLD(a_stall_vld, !w_adv, r_vld[LAT-2])

endmodule
